[sv/rti_pkg.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Shared widths, register indexes, word formats and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

   // Field widths
   localparam int unsigned COORD_W  = 16;
   localparam int unsigned EDGE_W   = COORD_W + 1;
   localparam int unsigned CROSS_W  = 2 * EDGE_W + 1;
   localparam int unsigned NUM_W    = 56;
   localparam int unsigned Q_W      = 32;
   localparam int unsigned FACE_W   = 16;
   localparam int unsigned EPS_W    = 48;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = EPS_W;
   localparam int unsigned FACE_BITS_DEF = 16;

   // Quotient bits below the saturation limit and fraction bits
   localparam int unsigned QUO_W  = Q_W - 1;
   localparam int unsigned FRAC_W = 16;

   localparam logic signed [Q_W-1:0] Q16_ONE = 32'sh0001_0000;
   localparam logic signed [Q_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q16_MIN = 32'sh8000_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_SIDED   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DET_EPSILON = 3'd7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic signed [Q_W-1:0]     q16_type;

   // Ray and mode settings
   typedef struct packed {
      coord_type [2:0]  org;
      coord_type [2:0]  dir;
      logic             two_sided;
      logic [EPS_W-1:0] eps;
   } cfg_type;

   // Input word: one triangle
   typedef struct packed {
      coord_type         a_x;
      coord_type         a_y;
      coord_type         a_z;
      coord_type         b_x;
      coord_type         b_y;
      coord_type         b_z;
      coord_type         c_x;
      coord_type         c_y;
      coord_type         c_z;
      logic [FACE_W-1:0] face_index;
      logic              first_of_ray;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic              hit;
      q16_type           dist_res;
      q16_type           bary_u;
      q16_type           bary_v;
      q16_type           bary_w;
      logic [FACE_W-1:0] hit_face;
      logic              nearest_valid;
      logic [FACE_W-1:0] nearest_face;
      q16_type           nearest_dist;
   } rsp_word_type;

   // Classified triangle passed from front to back
   typedef struct packed {
      num_type           det;
      num_type           un;
      num_type           vn;
      num_type           tn;
      logic [FACE_W-1:0] face;
      logic              first;
      logic              pass;
      logic              two_sided;
   } entry_type;

   typedef enum logic {
      BK_IDLE,
      BK_DIV
   } back_state_type;

endpackage

`default_nettype wire

[sv/rti_req_if.sv]
// ----------------------------------------------------------------------------
// Triangle channel
// Valid/ready channel that carries one triangle word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_req_if import rti_pkg::*;;
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[sv/rti_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one intersection result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_rsp_if import rti_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[sv/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersection engine
// Moller-Trumbore test of a stream of triangles against one configured ray.
// ----------------------------------------------------------------------------
// Usage: write origin, direction, face mode and determinant threshold
// through the csr_ port (index 0..7, one register per cycle, no read-back)
// while the engine is idle. Triangles enter on req_chan as valid/ready
// words; each word gives exactly one result word on rsp_chan with hit,
// t, u, v, w, the echoed face and the closest hit of the current ray.
// A word with first_of_ray set starts a new ray.
// Each word passes three front stages, the queue, the dividers and the
// output register. The three bit-serial dividers in the back end set the
// pace: they handle one triangle at a time, and the front and a
// two-word queue take up to five further triangles meanwhile.
// Reset restores the register defaults and clears the closest-hit record.
// When the receiver stalls, the result word holds, the back end waits and
// the front stops accepting once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect import rti_pkg::*; #(
   parameter int unsigned FACE_BITS = FACE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire [CSR_IDX_W-1:0]    csr_idx,
   input  wire [CSR_DATA_W-1:0]   csr_wdata,
   rti_req_if.sink                req_chan,
   rti_rsp_if.source              rsp_chan
);

   cfg_type   cfg_ff;
   entry_type f_entry, b_entry;
   logic      f_valid, f_ready, b_valid, b_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.org       <= '0;
         cfg_ff.dir       <= {16'sd256, 16'sd0, 16'sd0};
         cfg_ff.two_sided <= 1'b0;
         cfg_ff.eps       <= EPS_W'(17);
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_ORIGIN_X:    cfg_ff.org[0]    <= csr_wdata[COORD_W-1:0];
            REG_ORIGIN_Y:    cfg_ff.org[1]    <= csr_wdata[COORD_W-1:0];
            REG_ORIGIN_Z:    cfg_ff.org[2]    <= csr_wdata[COORD_W-1:0];
            REG_DIRECTION_X: cfg_ff.dir[0]    <= csr_wdata[COORD_W-1:0];
            REG_DIRECTION_Y: cfg_ff.dir[1]    <= csr_wdata[COORD_W-1:0];
            REG_DIRECTION_Z: cfg_ff.dir[2]    <= csr_wdata[COORD_W-1:0];
            REG_TWO_SIDED:   cfg_ff.two_sided <= csr_wdata[0];
            REG_DET_EPSILON: cfg_ff.eps       <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   rti_front u_front (
      .clock, .reset, .cfg(cfg_ff), .req_chan,
      .q_entry(f_entry), .q_valid(f_valid), .q_ready(f_ready)
   );

   rti_queue u_queue (
      .clock, .reset,
      .in_entry(f_entry), .in_valid(f_valid), .in_ready(f_ready),
      .out_entry(b_entry), .out_valid(b_valid), .out_ready(b_ready)
   );

   rti_back #(.FACE_BITS(FACE_BITS)) u_back (
      .clock, .reset,
      .q_entry(b_entry), .q_valid(b_valid), .q_ready(b_ready), .rsp_chan
   );

   // A hit is always recorded as the closest hit or beaten by one.
   a_hit_recorded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.word.hit |-> rsp_chan.word.nearest_valid)
      else $error("hit without a closest-hit record");

   // A miss reports zero distance and barycentrics.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.word.hit |->
         rsp_chan.word.dist_res == '0 && rsp_chan.word.bary_u == '0 &&
         rsp_chan.word.bary_v == '0 && rsp_chan.word.bary_w == '0)
      else $error("miss with nonzero payload");

   // A hit never lies behind the origin, and the record is no farther.
   a_hit_ahead: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.word.hit |->
         !rsp_chan.word.dist_res[Q_W-1] &&
         rsp_chan.word.nearest_dist <= rsp_chan.word.dist_res)
      else $error("hit with negative or farther distance");

   // A front word that the full queue refuses stays valid until it is taken.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |=> f_valid)
      else $error("front word dropped at the queue");

endmodule

`default_nettype wire

[sv/rti_front.sv]
// ----------------------------------------------------------------------------
// Intersection front end
// Three-stage pipeline: edges, cross products, dot products; then classifies
// the triangle against the culling mode and the determinant threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_front import rti_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  cfg_type     cfg,
   rti_req_if.sink     req_chan,
   output entry_type   q_entry,
   output logic        q_valid,
   input  wire         q_ready
);

   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [CROSS_W-1:0] cross_type;

   edge_type [2:0]  e1_ff, e2_ff, tv_ff, e1_in, e2_in, tv_in;
   edge_type [2:0]  e1b_ff, e2b_ff, tvb_ff;
   cross_type [2:0] pv_ff, qv_ff, pv_in, qv_in;
   num_type         det_ff, un_ff, vn_ff, tn_ff;
   num_type         det_in, un_in, vn_in, tn_in;
   logic [FACE_W-1:0] face1_ff, face2_ff, face3_ff;
   logic            first1_ff, first2_ff, first3_ff;
   logic            v1_ff, v2_ff, v3_ff;
   logic            adv;
   coord_type [2:0] va, vb, vc;
   num_type         eps_s, abs_det, uv_sum;
   logic            pass;

   // The whole pipeline moves when its last stage is free or drains.
   assign adv = !v3_ff || q_ready;
   assign req_chan.ready = adv;

   // Stage one: edges and origin offset.
   always_comb begin
      va = {req_chan.word.a_z, req_chan.word.a_y, req_chan.word.a_x};
      vb = {req_chan.word.b_z, req_chan.word.b_y, req_chan.word.b_x};
      vc = {req_chan.word.c_z, req_chan.word.c_y, req_chan.word.c_x};
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EDGE_W'(vb[i]) - EDGE_W'(va[i]);
         e2_in[i] = EDGE_W'(vc[i]) - EDGE_W'(va[i]);
         tv_in[i] = EDGE_W'(cfg.org[i]) - EDGE_W'(va[i]);
      end
   end

   // Stage two: P = D x E2 and Q = T x E1.
   always_comb begin
      pv_in[0] = CROSS_W'(cfg.dir[1]) * CROSS_W'(e2_ff[2])
               - CROSS_W'(cfg.dir[2]) * CROSS_W'(e2_ff[1]);
      pv_in[1] = CROSS_W'(cfg.dir[2]) * CROSS_W'(e2_ff[0])
               - CROSS_W'(cfg.dir[0]) * CROSS_W'(e2_ff[2]);
      pv_in[2] = CROSS_W'(cfg.dir[0]) * CROSS_W'(e2_ff[1])
               - CROSS_W'(cfg.dir[1]) * CROSS_W'(e2_ff[0]);
      qv_in[0] = CROSS_W'(tv_ff[1]) * CROSS_W'(e1_ff[2])
               - CROSS_W'(tv_ff[2]) * CROSS_W'(e1_ff[1]);
      qv_in[1] = CROSS_W'(tv_ff[2]) * CROSS_W'(e1_ff[0])
               - CROSS_W'(tv_ff[0]) * CROSS_W'(e1_ff[2]);
      qv_in[2] = CROSS_W'(tv_ff[0]) * CROSS_W'(e1_ff[1])
               - CROSS_W'(tv_ff[1]) * CROSS_W'(e1_ff[0]);
   end

   // Stage three: determinant and the three numerators.
   always_comb begin
      det_in = '0;
      un_in  = '0;
      vn_in  = '0;
      tn_in  = '0;
      for (int i = 0; i < 3; i++) begin
         det_in = det_in + NUM_W'(e1b_ff[i]) * NUM_W'(pv_ff[i]);
         un_in  = un_in  + NUM_W'(tvb_ff[i]) * NUM_W'(pv_ff[i]);
         vn_in  = vn_in  + NUM_W'(cfg.dir[i]) * NUM_W'(qv_ff[i]);
         tn_in  = tn_in  + NUM_W'(e2b_ff[i]) * NUM_W'(qv_ff[i]);
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff     <= e1_in;
         e2_ff     <= e2_in;
         tv_ff     <= tv_in;
         face1_ff  <= req_chan.word.face_index;
         first1_ff <= req_chan.word.first_of_ray;
         pv_ff     <= pv_in;
         qv_ff     <= qv_in;
         e1b_ff    <= e1_ff;
         e2b_ff    <= e2_ff;
         tvb_ff    <= tv_ff;
         face2_ff  <= face1_ff;
         first2_ff <= first1_ff;
         det_ff    <= det_in;
         un_ff     <= un_in;
         vn_ff     <= vn_in;
         tn_ff     <= tn_in;
         face3_ff  <= face2_ff;
         first3_ff <= first2_ff;
      end
   end

   // Classification: culled mode checks u and v against det here,
   // two-sided mode only checks the determinant magnitude.
   always_comb begin
      eps_s   = num_type'({1'b0, cfg.eps});
      abs_det = det_ff[NUM_W-1] ? -det_ff : det_ff;
      uv_sum  = un_ff + vn_ff;
      if (det_ff == '0) begin
         pass = 1'b0;
      end else if (!cfg.two_sided) begin
         pass = (det_ff >= eps_s) && !un_ff[NUM_W-1] && (un_ff <= det_ff)
             && !vn_ff[NUM_W-1] && (uv_sum <= det_ff);
      end else begin
         pass = abs_det >= eps_s;
      end
   end

   assign q_valid           = v3_ff;
   assign q_entry.det       = det_ff;
   assign q_entry.un        = un_ff;
   assign q_entry.vn        = vn_ff;
   assign q_entry.tn        = tn_ff;
   assign q_entry.face      = face3_ff;
   assign q_entry.first     = first3_ff;
   assign q_entry.pass      = pass;
   assign q_entry.two_sided = cfg.two_sided;

endmodule

`default_nettype wire

[sv/rti_queue.sv]
// ----------------------------------------------------------------------------
// Front-to-back queue
// Two-entry queue of classified triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_queue import rti_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  entry_type  in_entry,
   input  wire        in_valid,
   output logic       in_ready,
   output entry_type  out_entry,
   output logic       out_valid,
   input  wire        out_ready
);

   entry_type  slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = slot_ff[rd_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_entry;
   end

endmodule

`default_nettype wire

[sv/rti_div.sv]
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle, giving num/den as a
// saturated signed Q16.16 value with the magnitude truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div import rti_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  num_type  num,
   input  num_type  den,
   output logic     busy,
   output q16_type  quo
);

   localparam int unsigned LO_W  = QUO_W - FRAC_W;
   localparam int unsigned CNT_W = $clog2(QUO_W + 1);

   logic [NUM_W-1:0] an, ad, ad_ff;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W:0]   trial;
   logic [QUO_W-1:0] dsr_ff, quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff, sat_ff, busy_ff, ge;

   assign an    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign ad    = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
   assign trial = {rem_ff, dsr_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, ad_ff};

   // Control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(QUO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   // Datapath: the quotient is known to be below 2^31 unless saturated,
   // so the remainder starts from the dividend's upper part.
   always_ff @(posedge clock) begin
      if (start) begin
         ad_ff  <= ad;
         neg_ff <= num[NUM_W-1] ^ den[NUM_W-1];
         sat_ff <= (NUM_W + LO_W)'(an) >= {ad, LO_W'(0)};
         rem_ff <= an >> LO_W;
         dsr_ff <= {an[LO_W-1:0], FRAC_W'(0)};
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? NUM_W'(trial - {1'b0, ad_ff}) : NUM_W'(trial);
         dsr_ff <= dsr_ff << 1;
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign busy = busy_ff;

   always_comb begin
      if (sat_ff) quo = neg_ff ? Q16_MIN : Q16_MAX;
      else if (neg_ff) quo = -q16_type'({1'b0, quo_ff});
      else quo = q16_type'({1'b0, quo_ff});
   end

endmodule

`default_nettype wire

[sv/rti_back.sv]
// ----------------------------------------------------------------------------
// Intersection back end
// Runs the three divisions, decides the hit, keeps the closest hit of the
// current ray and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_back import rti_pkg::*; #(
   parameter int unsigned FACE_BITS = FACE_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  entry_type  q_entry,
   input  wire        q_valid,
   output logic       q_ready,
   rti_rsp_if.source  rsp_chan
);

   localparam int unsigned EXT_W = 32;

   back_state_type    state_ff, state_in;
   logic              start, load, busy_u, busy_v, busy_t;
   q16_type           u_q, v_q, t_q;
   logic [FACE_W-1:0] face_ff;
   logic              first_ff, pass_ff, two_ff;
   logic              rsp_v_ff;
   rsp_word_type      rsp_ff, rsp_in;
   logic              best_valid_ff, best_valid_in;
   q16_type           best_dist_ff, best_dist_in;
   logic [FACE_BITS-1:0] best_face_ff, best_face_in;
   logic [EXT_W-1:0]  face_ext, best_ext;
   logic              in_tri, hit;
   logic signed [Q_W:0]   uv_sum;
   logic signed [Q_W+1:0] w_wide;
   q16_type           w_q;

   // One divider for each quotient, all started together.
   rti_div u_div_u (.clock, .reset, .start, .num(q_entry.un), .den(q_entry.det),
                    .busy(busy_u), .quo(u_q));
   rti_div u_div_v (.clock, .reset, .start, .num(q_entry.vn), .den(q_entry.det),
                    .busy(busy_v), .quo(v_q));
   rti_div u_div_t (.clock, .reset, .start, .num(q_entry.tn), .den(q_entry.det),
                    .busy(busy_t), .quo(t_q));

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               start    = 1'b1;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (!(busy_u || busy_v || busy_t) && (!rsp_v_ff || rsp_chan.ready)) begin
               load     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign q_ready = start;

   // Side information of the triangle in flight.
   always_ff @(posedge clock) begin
      if (start) begin
         face_ff  <= q_entry.face;
         first_ff <= q_entry.first;
         pass_ff  <= q_entry.pass;
         two_ff   <= q_entry.two_sided;
      end
   end

   // Hit decision and closest-hit update.
   always_comb begin
      uv_sum   = (Q_W+1)'(u_q) + (Q_W+1)'(v_q);
      in_tri   = !u_q[Q_W-1] && (u_q <= Q16_ONE) && !v_q[Q_W-1]
              && (uv_sum <= (Q_W+1)'(Q16_ONE));
      hit      = pass_ff && (!two_ff || in_tri) && !t_q[Q_W-1];
      w_wide   = (Q_W+2)'(Q16_ONE) - (Q_W+2)'(u_q) - (Q_W+2)'(v_q);
      if (w_wide > (Q_W+2)'(Q16_MAX)) w_q = Q16_MAX;
      else if (w_wide < (Q_W+2)'(Q16_MIN)) w_q = Q16_MIN;
      else w_q = Q_W'(w_wide);

      face_ext = EXT_W'(face_ff);
      if (first_ff) begin
         best_valid_in = 1'b0;
         best_dist_in  = '0;
         best_face_in  = '0;
      end else begin
         best_valid_in = best_valid_ff;
         best_dist_in  = best_dist_ff;
         best_face_in  = best_face_ff;
      end
      if (hit && (!best_valid_in || t_q < best_dist_in)) begin
         best_valid_in = 1'b1;
         best_dist_in  = t_q;
         best_face_in  = face_ext[FACE_BITS-1:0];
      end
      best_ext = EXT_W'(best_face_in);

      rsp_in.hit           = hit;
      rsp_in.dist_res      = hit ? t_q : '0;
      rsp_in.bary_u        = hit ? u_q : '0;
      rsp_in.bary_v        = hit ? v_q : '0;
      rsp_in.bary_w        = hit ? w_q : '0;
      rsp_in.hit_face      = face_ff;
      rsp_in.nearest_valid = best_valid_in;
      rsp_in.nearest_face  = best_ext[FACE_W-1:0];
      rsp_in.nearest_dist  = best_dist_in;
   end

   // Closest-hit record.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         best_dist_ff  <= '0;
         best_face_ff  <= '0;
      end else if (load) begin
         best_valid_ff <= best_valid_in;
         best_dist_ff  <= best_dist_in;
         best_face_ff  <= best_face_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (load) rsp_v_ff <= 1'b1;
      else if (rsp_chan.ready) rsp_v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_v_ff;
   assign rsp_chan.word  = rsp_ff;

endmodule

`default_nettype wire

[verif/rti_checker.sv]
// ----------------------------------------------------------------------------
// Ray/triangle result checker
// Watches both channels, predicts each result word from the triangle words
// accepted so far and the register settings, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_checker import rti_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_idx,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  req_word_type         req_word,
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  rsp_word_type         rsp_word,
   output int                   error_count,
   output int                   pending_count
);

   // Shadow copy of the ray settings and the closest-hit record.
   longint            ray_org [3];
   longint            ray_dir [3];
   bit                mode_two_sided;
   longint            eps_value;
   longint            near_dist;
   logic [FACE_W-1:0] near_face;
   bit                near_valid;

   rsp_word_type expected_results[$];

   assign pending_count = expected_results.size();

   // Quotient num/den in Q16.16, magnitude truncated, saturated.
   function automatic longint q16_quotient(longint num, longint den);
      bit             neg;
      longint unsigned an, ad, q, r, mag;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = an / ad;
      r   = an % ad;
      if (q >= 64'h8000) return neg ? -64'sd2147483648 : 64'sd2147483647;
      mag = q;
      for (int i = 0; i < 16; i++) begin
         r   = r << 1;
         mag = mag << 1;
         if (r >= ad) begin
            r   = r - ad;
            mag = mag | 1;
         end
      end
      if (neg) return (mag >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(mag);
      return (mag > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(mag);
   endfunction

   // Intersection of the configured ray with one triangle.
   function automatic rsp_word_type predict_result(req_word_type tri_w);
      longint       va [3], vb [3], vc [3], e1 [3], e2 [3], tv [3], pv [3], qv [3];
      longint       det, un, vn, tn, t, u, v, w, ad;
      bit           hit;
      rsp_word_type res;
      va = '{longint'(tri_w.a_x), longint'(tri_w.a_y), longint'(tri_w.a_z)};
      vb = '{longint'(tri_w.b_x), longint'(tri_w.b_y), longint'(tri_w.b_z)};
      vc = '{longint'(tri_w.c_x), longint'(tri_w.c_y), longint'(tri_w.c_z)};
      t = 0; u = 0; v = 0; w = 0; hit = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = vb[i] - va[i];
         e2[i] = vc[i] - va[i];
         tv[i] = ray_org[i] - va[i];
      end
      if (tri_w.first_of_ray) begin
         near_valid = 0;
         near_dist  = 0;
         near_face  = '0;
      end
      pv[0] = ray_dir[1] * e2[2] - ray_dir[2] * e2[1];
      pv[1] = ray_dir[2] * e2[0] - ray_dir[0] * e2[2];
      pv[2] = ray_dir[0] * e2[1] - ray_dir[1] * e2[0];
      qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
      qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
      qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
      det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
      un  = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
      vn  = ray_dir[0] * qv[0] + ray_dir[1] * qv[1] + ray_dir[2] * qv[2];
      tn  = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
      if (det != 0) begin
         if (!mode_two_sided) begin
            if (det >= eps_value && un >= 0 && un <= det && vn >= 0 && un + vn <= det) begin
               t = q16_quotient(tn, det);
               u = q16_quotient(un, det);
               v = q16_quotient(vn, det);
               hit = 1;
            end
         end else begin
            ad = (det < 0) ? -det : det;
            if (ad >= eps_value) begin
               u = q16_quotient(un, det);
               v = q16_quotient(vn, det);
               if (u >= 0 && u <= 65536 && v >= 0 && u + v <= 65536) begin
                  t = q16_quotient(tn, det);
                  hit = 1;
               end
            end
         end
      end
      // A hit behind the origin is dropped.
      if (hit && t < 0) hit = 0;
      if (hit) begin
         w = 65536 - u - v;
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         if (!near_valid || t < near_dist) begin
            near_valid = 1;
            near_dist  = t;
            near_face  = tri_w.face_index;
         end
      end else begin
         t = 0; u = 0; v = 0; w = 0;
      end
      res.hit           = hit;
      res.dist_res      = q16_type'(t);
      res.bary_u        = q16_type'(u);
      res.bary_v        = q16_type'(v);
      res.bary_w        = q16_type'(w);
      res.hit_face      = tri_w.face_index;
      res.nearest_valid = near_valid;
      res.nearest_face  = near_face;
      res.nearest_dist  = q16_type'(near_dist);
      return res;
   endfunction

   // Register writes, predictions and comparisons, all at the clock edge.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         ray_org        = '{0, 0, 0};
         ray_dir        = '{0, 0, 256};
         mode_two_sided = 0;
         eps_value      = 17;
         near_dist      = 0;
         near_face      = '0;
         near_valid     = 0;
         error_count    <= 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx)
               REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: begin
                  ray_org[csr_idx] = longint'(coord_type'(csr_wdata[COORD_W-1:0]));
               end
               REG_DIRECTION_X, REG_DIRECTION_Y, REG_DIRECTION_Z: begin
                  ray_dir[csr_idx - REG_DIRECTION_X] =
                     longint'(coord_type'(csr_wdata[COORD_W-1:0]));
               end
               REG_TWO_SIDED: begin
                  mode_two_sided = csr_wdata[0];
               end
               REG_DET_EPSILON: begin
                  eps_value = longint'({16'd0, csr_wdata[EPS_W-1:0]});
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.insert(expected_results.size(), predict_result(req_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_word);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_word) begin
                  $display("%0t: mismatch hit %0d/%0d t %0d/%0d u %0d/%0d v %0d/%0d",
                     $time, want.hit, rsp_word.hit, want.dist_res, rsp_word.dist_res,
                     want.bary_u, rsp_word.bary_u, want.bary_v, rsp_word.bary_v);
                  $display("%0t:   w %0d/%0d face %0d/%0d near %0d/%0d %0d/%0d %0d/%0d",
                     $time, want.bary_w, rsp_word.bary_w, want.hit_face,
                     rsp_word.hit_face, want.nearest_valid, rsp_word.nearest_valid,
                     want.nearest_face, rsp_word.nearest_face, want.nearest_dist,
                     rsp_word.nearest_dist);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersection testbench
// Drives directed and random triangles under several ray settings with
// random gaps and stalls; a checker beside the engine predicts each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import rti_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_idx = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    error_count;
   int                    pending_count;
   int                    idle_cycles = 0;
   bit                    long_hold = 0;

   rti_req_if req_chan ();
   rti_rsp_if rsp_chan ();

   ray_triangle_intersect u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   rti_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_word     (req_chan.word),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_word     (rsp_chan.word),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Gap length: mostly short, now and then long.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: random stalls, plus one long hold-off requested by stimulus.
   initial begin
      int hold;
      rsp_chan.ready = 0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 0;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            long_hold = 0;
         end else begin
            hold = gap_length();
            if (hold == 0) begin
               rsp_chan.ready <= 1;
               @(posedge clock);
            end else begin
               rsp_chan.ready <= 0;
               repeat (hold) @(posedge clock);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One register write, after which the port is left idle.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 0;
      @(posedge clock);
   endtask

   // Wait for the engine to drain before a settings change or the end.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_triangle(req_word_type tri_w, bit with_gap);
      int gap;
      gap = with_gap ? gap_length() : 0;
      if (gap != 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.word  <= tri_w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   // Random triangle; small spans around the ray give real hits.
   function automatic req_word_type rand_triangle(int span);
      req_word_type w;
      w.a_x = rand_coord(span); w.a_y = rand_coord(span); w.a_z = rand_coord(span);
      w.b_x = rand_coord(span); w.b_y = rand_coord(span); w.b_z = rand_coord(span);
      w.c_x = rand_coord(span); w.c_y = rand_coord(span); w.c_z = rand_coord(span);
      w.face_index   = FACE_W'($urandom);
      w.first_of_ray = ($urandom_range(0, 7) == 0);
      return w;
   endfunction

   function automatic req_word_type make_triangle(int ax, int ay, int az, int bx, int by,
         int bz, int cx, int cy, int cz, int face, bit first);
      req_word_type w;
      w = '{coord_type'(ax), coord_type'(ay), coord_type'(az), coord_type'(bx),
            coord_type'(by), coord_type'(bz), coord_type'(cx), coord_type'(cy),
            coord_type'(cz), FACE_W'(face), first};
      return w;
   endfunction

   task automatic configure_ray(bit extreme, bit two_sided_mode);
      logic [CSR_DATA_W-1:0] eps;
      if (extreme) begin
         write_register(REG_ORIGIN_X, $urandom_range(0, 1) ? 48'h8000 : 48'h7FFF);
         write_register(REG_ORIGIN_Y, $urandom_range(0, 1) ? 48'h8000 : 48'h7FFF);
         write_register(REG_ORIGIN_Z, 48'($urandom));
         write_register(REG_DIRECTION_X, $urandom_range(0, 1) ? 48'h8000 : 48'h7FFF);
         write_register(REG_DIRECTION_Y, 48'($urandom));
         write_register(REG_DIRECTION_Z, $urandom_range(0, 1) ? 48'h8000 : 48'h7FFF);
      end else begin
         write_register(REG_ORIGIN_X, 48'(rand_coord(512)));
         write_register(REG_ORIGIN_Y, 48'(rand_coord(512)));
         write_register(REG_ORIGIN_Z, 48'(rand_coord(1024)));
         write_register(REG_DIRECTION_X, 48'(rand_coord(128)));
         write_register(REG_DIRECTION_Y, 48'(rand_coord(128)));
         write_register(REG_DIRECTION_Z, 48'(rand_coord(512)));
      end
      write_register(REG_TWO_SIDED, 48'(two_sided_mode));
      case ($urandom_range(0, 4))
         0: eps = '0;
         1: eps = '1;
         2: eps = 48'({$urandom, $urandom});
         default: eps = 48'($urandom_range(0, 1000));
      endcase
      write_register(REG_DET_EPSILON, eps);
   endtask

   initial begin
      req_word_type tri_w;
      req_chan.valid = 0;
      req_chan.word  = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default ray along +z from the origin.
      send_triangle(make_triangle(-256, -256, 512, 256, -256, 512, -256, 256, 512, 1, 1), 0);
      send_triangle(make_triangle(-256, -256, 512, -256, 256, 512, 256, -256, 512, 2, 0), 0);
      send_triangle(make_triangle(-256, -256, -512, 256, -256, -512, -256, 256, -512, 3, 0), 0);
      send_triangle(make_triangle(-256, -256, 256, 256, -256, 256, -256, 256, 256, 4, 0), 0);
      send_triangle(make_triangle(-256, -256, 256, 256, -256, 256, -256, 256, 256, 5, 0), 0);
      send_triangle(make_triangle(0, 0, 256, 256, 0, 256, 0, 256, 256, 6, 0), 0);
      send_triangle(make_triangle(256, 256, 256, 512, 256, 256, 256, 512, 256, 7, 0), 0);
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1), 0);
      send_triangle(make_triangle(-32768, -32768, 1, 32767, -32768, 1, -32768, 32767, 1,
                                  16'hFFFF, 0), 0);
      send_triangle(make_triangle(32767, 32767, 32767, -32768, -32768, -32768, 32767,
                                  -32768, 32767, 0, 1), 0);
      send_triangle(make_triangle(-1, -1, 32767, 1, -1, 32767, -1, 1, 32767, 9, 0), 0);
      send_triangle(make_triangle(-32768, -32768, 32767, 32767, -32768, 32767, -32768,
                                  32767, 32767, 10, 0), 0);
      req_chan.valid <= 0;
      wait_drained();

      // Two-sided mode with a zero threshold, back faces and degenerate ones.
      write_register(REG_TWO_SIDED, 48'd1);
      write_register(REG_DET_EPSILON, 48'd0);
      send_triangle(make_triangle(-256, -256, 512, -256, 256, 512, 256, -256, 512, 11, 1), 0);
      send_triangle(make_triangle(-256, -256, 512, 256, -256, 512, -256, 256, 512, 12, 0), 0);
      send_triangle(make_triangle(0, 0, 512, 256, 256, 512, 512, 512, 512, 13, 0), 0);
      send_triangle(make_triangle(-256, -256, -256, 256, -256, -256, -256, 256, -256, 14, 0),
                    0);
      send_triangle(make_triangle(-1, -1, 1, 1, -1, 1, -1, 1, 1, 15, 0), 0);
      req_chan.valid <= 0;
      wait_drained();

      // Random phases under varied settings; one long receiver hold-off.
      for (int phase = 0; phase < 10; phase++) begin
         configure_ray(phase == 2 || phase == 7, phase[0]);
         for (int n = 0; n < 50; n++) begin
            if (phase == 4 && n == 5) long_hold = 1;
            case ($urandom_range(0, 9))
               0:       tri_w = rand_triangle(0);
               1, 2:    tri_w = rand_triangle(4096);
               default: tri_w = rand_triangle(768);
            endcase
            send_triangle(tri_w, !(phase == 4 && n >= 5 && n < 25) && phase != 6);
         end
         req_chan.valid <= 0;
         wait_drained();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
sv/rti_pkg.sv
sv/rti_req_if.sv
sv/rti_rsp_if.sv
sv/rti_front.sv
sv/rti_queue.sv
sv/rti_div.sv
sv/rti_back.sv
sv/ray_triangle_intersect.sv
verif/rti_checker.sv
verif/testbench.sv
